FILE: sv/shh_pkg.sv
// ---------------------------------------------------------------------------
// shh_pkg
// Shared constants, tag codes and types for the heap header tracker.
// ---------------------------------------------------------------------------
package shh_pkg;

    localparam int TABLE_DEPTH   = 8192;
    localparam int BOARD_COUNT   = 64;
    localparam int CHANNEL_COUNT = 4096;

    localparam int SLOT_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int BOARD_IW = (BOARD_COUNT > 1) ? $clog2(BOARD_COUNT) : 1;
    localparam int CHAN_IW  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    localparam int VALUE_W = 48;
    localparam int TAG_W   = 15;
    localparam int COUNT_W = 16;

    localparam logic [TAG_W-1:0] TAG_HEAP_ID   = 15'h0001;
    localparam logic [TAG_W-1:0] TAG_HEAP_SIZE = 15'h0002;
    localparam logic [TAG_W-1:0] TAG_RECV_LEN  = 15'h0004;
    localparam logic [TAG_W-1:0] TAG_BOARD     = 15'h4101;
    localparam logic [TAG_W-1:0] TAG_CHANNEL   = 15'h4103;

    typedef enum logic [1:0] {
        ST_PARSE,
        ST_SEARCH,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic [VALUE_W-1:0] id;
        logic [VALUE_W-1:0] size;
        logic [VALUE_W-1:0] recv;
        logic [VALUE_W-1:0] board;
        logic [VALUE_W-1:0] chan;
    } t_fields;

    typedef struct packed {
        logic [VALUE_W-1:0] id;
        logic [VALUE_W-1:0] size;
        logic [63:0]        recv;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic                board_we;
        logic [BOARD_IW-1:0] board_idx;
        logic                chan_we;
        logic [CHAN_IW-1:0]  chan_idx;
    } t_mark;

endpackage

FILE: sv/shh_if.sv
// ---------------------------------------------------------------------------
// shh_if
// Valid/ready stream interfaces for packet words and per-packet results.
// ---------------------------------------------------------------------------
interface shh_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] word;
    logic        start_of_packet;

    modport source (output valid, output word, output start_of_packet, input ready);
    modport sink   (input valid, input word, input start_of_packet, output ready);
endinterface

interface shh_out_if;
    logic        valid;
    logic        ready;
    logic [12:0] slot;
    logic        new_heap;
    logic        table_full_drop;
    logic        board_out_of_range;
    logic        channel_out_of_range;
    logic [47:0] heap_number;
    logic [47:0] stored_size;
    logic [63:0] received_total;
    logic [13:0] entries_used;

    modport source (
        output valid, output slot, output new_heap, output table_full_drop,
        output board_out_of_range, output channel_out_of_range, output heap_number,
        output stored_size, output received_total, output entries_used,
        input ready
    );
    modport sink (
        input valid, input slot, input new_heap, input table_full_drop,
        input board_out_of_range, input channel_out_of_range, input heap_number,
        input stored_size, input received_total, input entries_used,
        output ready
    );
endinterface

FILE: sv/shh_table_ram.sv
// ---------------------------------------------------------------------------
// shh_table_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module shh_table_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/shh_parser.sv
// ---------------------------------------------------------------------------
// shh_parser
// Walks the header and item words of a packet and collects tagged fields.
// ---------------------------------------------------------------------------
module shh_parser
    import shh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [63:0] i_word,
    input  logic        i_sop,
    output t_fields     o_fields,
    output logic        o_done
);

    logic [COUNT_W-1:0] r_items_left;
    logic [COUNT_W-1:0] n_items_left;
    t_fields            r_fields;
    t_fields            n_fields;
    logic [TAG_W-1:0]   tag;
    logic [VALUE_W-1:0] value;

    assign tag   = i_word[62:48];
    assign value = i_word[VALUE_W-1:0];

    always_comb begin
        n_items_left = r_items_left;
        n_fields     = r_fields;
        o_done       = 1'b0;
        if (i_fire) begin
            if (i_sop) begin
                // new header abandons any unfinished packet
                n_fields     = '0;
                n_items_left = i_word[COUNT_W-1:0];
                o_done       = (n_items_left == '0);
            end else if (r_items_left != '0) begin
                case (tag)
                    TAG_HEAP_ID:   n_fields.id    = value;
                    TAG_HEAP_SIZE: n_fields.size  = value;
                    TAG_RECV_LEN:  n_fields.recv  = value;
                    TAG_BOARD:     n_fields.board = value;
                    TAG_CHANNEL:   n_fields.chan  = value;
                    default:       n_fields       = r_fields;
                endcase
                n_items_left = r_items_left - 1'b1;
                o_done       = (n_items_left == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_items_left <= '0;
            r_fields     <= '0;
        end else begin
            r_items_left <= n_items_left;
            r_fields     <= n_fields;
        end
    end

    assign o_fields = r_fields;

endmodule

FILE: sv/shh_seen.sv
// ---------------------------------------------------------------------------
// shh_seen
// Board and channel seen-maps; the channel map is cleared by a sweep.
// ---------------------------------------------------------------------------
module shh_seen
    import shh_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_mark i_mark,
    output logic  o_busy
);

    logic [BOARD_COUNT-1:0] r_board_seen;
    logic                   r_chan_mem [CHANNEL_COUNT];
    logic [CHAN_IW-1:0]     r_clr_idx;
    logic                   r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_seen <= '0;
        end else if (i_mark.board_we) begin
            r_board_seen[i_mark.board_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == CHAN_IW'(CHANNEL_COUNT - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_chan_mem[r_clr_idx] <= 1'b0;
        end else if (i_mark.chan_we) begin
            r_chan_mem[i_mark.chan_idx] <= 1'b1;
        end
    end

    assign o_busy = r_clearing;

endmodule

FILE: sv/spead_heap_header_tracker.sv
// ---------------------------------------------------------------------------
// spead_heap_header_tracker
// Parses packet headers, looks up the heap table and accumulates lengths.
// ---------------------------------------------------------------------------
// throughput: one packet word per cycle while a packet is being parsed
// after the last word: search walks the table newest first, one entry per
// cycle, until an id match or the table is exhausted, then the commit state
// writes the entry (unless dropped) and registers the result once the output is free
// reset: synchronous; after reset the channel map is swept to clear all
// CHANNEL_COUNT (4096) entries, with the input held not ready
module spead_heap_header_tracker
    import shh_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    shh_in_if.sink    i_in,
    shh_out_if.source o_out
);

    t_state             r_state;
    t_state             n_state;
    t_fields            fields;
    logic               pkt_done;
    logic               in_fire;
    logic               seen_busy;
    t_mark              mark;

    logic [CNT_W-1:0]   r_used;
    logic [CNT_W-1:0]   r_left;
    logic               r_pend;
    logic [SLOT_W-1:0]  r_pend_addr;
    logic               r_found;
    logic [SLOT_W-1:0]  r_slot;
    logic [VALUE_W-1:0] r_hit_size;
    logic [63:0]        r_hit_recv;

    logic               ram_re;
    logic [SLOT_W-1:0]  ram_raddr;
    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr;
    t_entry             ram_wdata;
    t_entry             ram_rdata;

    logic               match;
    logic               out_free;
    logic               drop;
    logic               insert;
    logic               board_oor;
    logic               chan_oor;
    logic               commit_fire;
    logic [CNT_W-1:0]   used_next;

    logic               r_out_valid;
    logic [12:0]        r_o_slot;
    logic               r_o_new;
    logic               r_o_drop;
    logic               r_o_board_oor;
    logic               r_o_chan_oor;
    logic [47:0]        r_o_heap;
    logic [47:0]        r_o_size;
    logic [63:0]        r_o_total;
    logic [13:0]        r_o_used;

    assign i_in.ready = (r_state == ST_PARSE) && !seen_busy;
    assign in_fire    = i_in.valid && i_in.ready;

    shh_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (in_fire),
        .i_word   (i_in.word),
        .i_sop    (i_in.start_of_packet),
        .o_fields (fields),
        .o_done   (pkt_done)
    );

    shh_table_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (SLOT_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    shh_seen u_seen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mark  (mark),
        .o_busy  (seen_busy)
    );

    assign match       = r_pend && (ram_rdata.id == fields.id);
    assign out_free    = !r_out_valid || o_out.ready;
    assign drop        = !r_found && (r_used == CNT_W'(TABLE_DEPTH));
    assign insert      = !r_found && !drop;
    assign board_oor   = fields.board >= VALUE_W'(BOARD_COUNT);
    assign chan_oor    = fields.chan >= VALUE_W'(CHANNEL_COUNT);
    assign commit_fire = (r_state == ST_COMMIT) && out_free;
    assign used_next   = insert ? r_used + 1'b1 : r_used;
    assign ram_raddr   = SLOT_W'(r_left - 1'b1);
    assign ram_waddr   = r_found ? r_slot : SLOT_W'(r_used);

    always_comb begin
        ram_wdata.id   = fields.id;
        ram_wdata.size = r_found ? r_hit_size : fields.size;
        // a fresh entry starts from zero received
        ram_wdata.recv = (r_found ? r_hit_recv : 64'd0) + {16'd0, fields.recv};
    end

    always_comb begin
        mark.board_we  = commit_fire && !drop && !board_oor;
        mark.board_idx = fields.board[BOARD_IW-1:0];
        mark.chan_we   = commit_fire && !drop && !chan_oor;
        mark.chan_idx  = fields.chan[CHAN_IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_PARSE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        ram_re  = 1'b0;
        ram_we  = 1'b0;
        case (r_state)
            ST_PARSE: begin
                if (pkt_done) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                ram_re = (r_left != '0);
                if (match || r_left == '0) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    ram_we  = !drop;
                    n_state = ST_PARSE;
                end
            end
            default: begin
                n_state = ST_PARSE;
            end
        endcase
    end

    // search pipeline: address issued one cycle, id compared the next
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_left  <= '0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            case (r_state)
                ST_PARSE: begin
                    if (pkt_done) begin
                        r_left  <= r_used;
                        r_pend  <= 1'b0;
                        r_found <= 1'b0;
                    end
                end
                ST_SEARCH: begin
                    r_pend <= (r_left != '0);
                    if (r_left != '0) begin
                        r_left <= r_left - 1'b1;
                    end
                    if (match) begin
                        r_found <= 1'b1;
                    end
                end
                ST_COMMIT: begin
                    if (out_free) begin
                        r_used <= used_next;
                    end
                end
                default: begin
                    r_pend <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SEARCH) begin
            r_pend_addr <= ram_raddr;
            if (match) begin
                r_slot     <= r_pend_addr;
                r_hit_size <= ram_rdata.size;
                r_hit_recv <= ram_rdata.recv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit_fire) begin
            r_o_slot      <= drop ? 13'd0 : 13'(ram_waddr);
            r_o_new       <= insert;
            r_o_drop      <= drop;
            r_o_board_oor <= board_oor;
            r_o_chan_oor  <= chan_oor;
            r_o_heap      <= fields.id;
            r_o_size      <= drop ? 48'd0 : ram_wdata.size;
            r_o_total     <= drop ? 64'd0 : ram_wdata.recv;
            r_o_used      <= 14'(used_next);
        end
    end

    assign o_out.valid                = r_out_valid;
    assign o_out.slot                 = r_o_slot;
    assign o_out.new_heap             = r_o_new;
    assign o_out.table_full_drop      = r_o_drop;
    assign o_out.board_out_of_range   = r_o_board_oor;
    assign o_out.channel_out_of_range = r_o_chan_oor;
    assign o_out.heap_number          = r_o_heap;
    assign o_out.stored_size          = r_o_size;
    assign o_out.received_total       = r_o_total;
    assign o_out.entries_used         = r_o_used;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_DEPTH))
        else $error("table fill count beyond depth");

    a_drop_not_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_o_new && r_o_drop))
        else $error("dropped packet reported as new heap");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit_fire && insert |=> r_used == $past(r_used) + 1'b1)
        else $error("insert did not advance fill count");

    a_search_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) && (r_left != '0) && !match
        |=> (r_state == ST_SEARCH) && (r_left == $past(r_left) - 1'b1))
        else $error("search walk skipped an entry");

    a_done_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && pkt_done |=> r_state == ST_SEARCH)
        else $error("finished packet did not start a search");

endmodule
